### hw/rtl/gcs_pkg.sv
// Shared types and constants for the gradient color sampler.
// Used by the sampler, divider and blend modules; depends on nothing.
package gcs_pkg;

  localparam int unsigned STOP_W     = 32;
  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned STOP_IDX_W = 3;
  localparam int unsigned NUM_STOPS  = 6;

  localparam logic [STOP_IDX_W-1:0] MAX_STOPS = 3'd6;

  // Divider produces one quotient bit per step
  localparam int unsigned DIV_STEPS = FRAC_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STOP_COUNT,
    REG_BLEND_MODE,
    REG_STOP_0,
    REG_STOP_1,
    REG_STOP_2,
    REG_STOP_3,
    REG_STOP_4,
    REG_STOP_5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BLEND_LERP,
    BLEND_LOWER,
    BLEND_UPPER,
    BLEND_NEAREST
  } blend_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_BLEND,
    ST_DONE
  } gcs_state_t;

  // 8-bit stop position on the 16-bit scale: p * 257
  function automatic logic [POS_W-1:0] stop_pos16(input logic [STOP_W-1:0] s);
    stop_pos16 = {s[31:24], s[31:24]};
  endfunction

endpackage

### hw/rtl/gradient_color_sampler.sv
// Gradient color sampler top level: config registers, sequencer and datapath.
// Depends on gcs_pkg, gcs_divider and gcs_blend.
//
// A request is taken when start is high and busy is low; busy then stays high
// until the result strobe out_valid has shown the color for one cycle, and the
// receiver must take it in that cycle. With no stops in use the block goes
// straight to the result. Otherwise the stops are scanned one per cycle, up to
// the first stop above the position or the last stop in use; an end color then
// skips the 8-step bit-serial divider that forms a blend factor, and the three
// channels go through one shared multiplier. Configuration must be written only
// while busy is low; the block itself does not enforce this.
module gradient_color_sampler (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [gcs_pkg::POS_W-1:0]         in_position,
  output logic                              out_valid,
  output logic [gcs_pkg::CH_W-1:0]          out_red,
  output logic [gcs_pkg::CH_W-1:0]          out_green,
  output logic [gcs_pkg::CH_W-1:0]          out_blue,
  input  logic                              cfg_wr_en,
  input  logic [gcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gcs_pkg::STOP_W-1:0]        cfg_data
);

  // configuration
  logic [gcs_pkg::STOP_IDX_W-1:0] stop_count_r;
  gcs_pkg::blend_mode_t           blend_mode_r;
  logic [gcs_pkg::STOP_W-1:0]     stop_r [gcs_pkg::NUM_STOPS];
  logic [gcs_pkg::STOP_IDX_W-1:0] stop_wr_idx;

  // sequencer and datapath
  gcs_pkg::gcs_state_t            state_r, state_nxt;
  logic [gcs_pkg::STOP_IDX_W-1:0] idx_r, idx_nxt;
  logic [1:0]                     ch_r, ch_nxt;
  logic [gcs_pkg::POS_W-1:0]      t_r, t_nxt;
  logic [gcs_pkg::STOP_W-1:0]     prev_r, prev_nxt;
  logic [gcs_pkg::COLOR_W-1:0]    lo_r, lo_nxt;
  logic [gcs_pkg::COLOR_W-1:0]    up_r, up_nxt;
  logic [gcs_pkg::FRAC_W-1:0]     f_r, f_nxt;
  logic [gcs_pkg::CH_W-1:0]       red_r, red_nxt;
  logic [gcs_pkg::CH_W-1:0]       green_r, green_nxt;
  logic [gcs_pkg::CH_W-1:0]       blue_r, blue_nxt;

  logic [gcs_pkg::STOP_IDX_W-1:0] n_eff;
  logic [gcs_pkg::STOP_W-1:0]     cur_stop;
  logic [gcs_pkg::POS_W-1:0]      cur_pos;
  logic [gcs_pkg::POS_W-1:0]      prev_pos;
  logic                           above;
  logic                           last;
  logic                           accept;

  logic                           div_load;
  logic                           div_done;
  logic [gcs_pkg::FRAC_W-1:0]     div_quot;
  logic [gcs_pkg::CH_W-1:0]       blend_lo;
  logic [gcs_pkg::CH_W-1:0]       blend_up;
  logic [gcs_pkg::CH_W-1:0]       blend_val;

  assign stop_wr_idx = cfg_index - gcs_pkg::REG_STOP_0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_count_r <= '0;
      blend_mode_r <= gcs_pkg::BLEND_LERP;
      for (int i = 0; i < gcs_pkg::NUM_STOPS; i++) begin
        stop_r[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      case (cfg_index)
        gcs_pkg::REG_STOP_COUNT: stop_count_r <= cfg_data[gcs_pkg::STOP_IDX_W-1:0];
        gcs_pkg::REG_BLEND_MODE: blend_mode_r <= gcs_pkg::blend_mode_t'(cfg_data[1:0]);
        default: stop_r[stop_wr_idx] <= cfg_data;
      endcase
    end
  end

  assign n_eff    = (stop_count_r > gcs_pkg::MAX_STOPS) ? gcs_pkg::MAX_STOPS : stop_count_r;
  assign cur_stop = stop_r[idx_r];
  assign cur_pos  = gcs_pkg::stop_pos16(cur_stop);
  assign prev_pos = gcs_pkg::stop_pos16(prev_r);
  assign above    = (cur_pos > t_r);
  assign last     = (idx_r == n_eff - 1'b1);
  assign accept   = start && (state_r == gcs_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gcs_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = (n_eff == '0) ? gcs_pkg::ST_DONE : gcs_pkg::ST_SCAN;
        end
      end
      gcs_pkg::ST_SCAN: begin
        if (above && (idx_r != '0)) begin
          state_nxt = gcs_pkg::ST_DIV;
        end else if (above || last) begin
          state_nxt = gcs_pkg::ST_BLEND;
        end
      end
      gcs_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = gcs_pkg::ST_BLEND;
        end
      end
      gcs_pkg::ST_BLEND: begin
        if (ch_r == 2'd2) begin
          state_nxt = gcs_pkg::ST_DONE;
        end
      end
      gcs_pkg::ST_DONE: state_nxt = gcs_pkg::ST_IDLE;
      default:          state_nxt = gcs_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    idx_nxt   = idx_r;
    ch_nxt    = ch_r;
    t_nxt     = t_r;
    prev_nxt  = prev_r;
    lo_nxt    = lo_r;
    up_nxt    = up_r;
    f_nxt     = f_r;
    red_nxt   = red_r;
    green_nxt = green_r;
    blue_nxt  = blue_r;
    div_load  = 1'b0;
    case (state_r)
      gcs_pkg::ST_IDLE: begin
        if (accept) begin
          t_nxt     = in_position;
          idx_nxt   = '0;
          ch_nxt    = '0;
          red_nxt   = '0;
          green_nxt = '0;
          blue_nxt  = '0;
        end
      end
      gcs_pkg::ST_SCAN: begin
        if (above && (idx_r != '0)) begin
          lo_nxt   = prev_r[gcs_pkg::COLOR_W-1:0];
          up_nxt   = cur_stop[gcs_pkg::COLOR_W-1:0];
          div_load = 1'b1;
        end else if (above || last) begin
          // end color: equal colors blend to themselves in every mode
          lo_nxt = cur_stop[gcs_pkg::COLOR_W-1:0];
          up_nxt = cur_stop[gcs_pkg::COLOR_W-1:0];
          f_nxt  = '0;
        end else begin
          prev_nxt = cur_stop;
          idx_nxt  = idx_r + 1'b1;
        end
      end
      gcs_pkg::ST_DIV: begin
        if (div_done) begin
          f_nxt = div_quot;
        end
      end
      gcs_pkg::ST_BLEND: begin
        ch_nxt = ch_r + 1'b1;
        case (ch_r)
          2'd0:    red_nxt   = blend_val;
          2'd1:    green_nxt = blend_val;
          default: blue_nxt  = blend_val;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    case (ch_r)
      2'd0: begin
        blend_lo = lo_r[23:16];
        blend_up = up_r[23:16];
      end
      2'd1: begin
        blend_lo = lo_r[15:8];
        blend_up = up_r[15:8];
      end
      default: begin
        blend_lo = lo_r[7:0];
        blend_up = up_r[7:0];
      end
    endcase
  end

  gcs_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (div_load),
    .num   (t_r - prev_pos),
    .den   (cur_pos - prev_pos),
    .done  (div_done),
    .quot  (div_quot)
  );

  gcs_blend u_blend (
    .lo_ch (blend_lo),
    .up_ch (blend_up),
    .frac  (f_r),
    .mode  (blend_mode_r),
    .value (blend_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gcs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    ch_r    <= ch_nxt;
    t_r     <= t_nxt;
    prev_r  <= prev_nxt;
    lo_r    <= lo_nxt;
    up_r    <= up_nxt;
    f_r     <= f_nxt;
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
  end

  assign busy      = (state_r != gcs_pkg::ST_IDLE);
  assign out_valid = (state_r == gcs_pkg::ST_DONE);
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule

### hw/rtl/gcs_divider.sv
// Restoring divider: quotient = floor(num * 2^DIV_STEPS / den), one bit per cycle.
// Requires num < den. Depends on gcs_pkg.
module gcs_divider (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load,
  input  logic [gcs_pkg::POS_W-1:0]      num,
  input  logic [gcs_pkg::POS_W-1:0]      den,
  output logic                           done,
  output logic [gcs_pkg::FRAC_W-1:0]     quot
);

  logic [gcs_pkg::POS_W-1:0]     rem_r, rem_nxt;
  logic [gcs_pkg::POS_W-1:0]     den_r;
  logic [gcs_pkg::FRAC_W-1:0]    quot_r, quot_nxt;
  logic [gcs_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          done_r, done_nxt;
  logic [gcs_pkg::POS_W:0]       rem_sh;
  logic [gcs_pkg::POS_W:0]       rem_sub;
  logic                          ge;

  assign rem_sh  = {rem_r, 1'b0};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign ge      = (rem_sh >= {1'b0, den_r});

  always_comb begin
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (load) begin
      rem_nxt  = num;
      quot_nxt = '0;
      cnt_nxt  = gcs_pkg::DIV_CNT_W'(gcs_pkg::DIV_STEPS);
    end else if (cnt_r != '0) begin
      // remainder stays below den, so the low bits hold it either way
      rem_nxt  = ge ? rem_sub[gcs_pkg::POS_W-1:0] : rem_sh[gcs_pkg::POS_W-1:0];
      quot_nxt = {quot_r[gcs_pkg::FRAC_W-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == gcs_pkg::DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    if (load) begin
      den_r <= den;
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

### hw/rtl/gcs_blend.sv
// Per-channel blend of a lower and an upper color byte by a Q0.8 factor.
// One channel per use; depends on gcs_pkg.
module gcs_blend (
  input  logic [gcs_pkg::CH_W-1:0]   lo_ch,
  input  logic [gcs_pkg::CH_W-1:0]   up_ch,
  input  logic [gcs_pkg::FRAC_W-1:0] frac,
  input  gcs_pkg::blend_mode_t       mode,
  output logic [gcs_pkg::CH_W-1:0]   value
);

  logic signed [gcs_pkg::CH_W:0]       diff;
  logic signed [2*gcs_pkg::CH_W+1:0]   prod;

  assign diff = $signed({1'b0, up_ch}) - $signed({1'b0, lo_ch});
  assign prod = diff * $signed({1'b0, frac});

  always_comb begin
    case (mode)
      // arithmetic shift right by 8 floors the signed product
      gcs_pkg::BLEND_LERP:    value = lo_ch + prod[2*gcs_pkg::CH_W-1:gcs_pkg::CH_W];
      gcs_pkg::BLEND_LOWER:   value = lo_ch;
      gcs_pkg::BLEND_UPPER:   value = up_ch;
      gcs_pkg::BLEND_NEAREST: value = frac[gcs_pkg::FRAC_W-1] ? up_ch : lo_ch;
      default:                value = lo_ch;
    endcase
  end

endmodule

### hw/rtl/gcs_checker.sv
// Port-level checks on the gradient color sampler's request/result sequencing.
// Bound to gradient_color_sampler; watches only its handshake ports.
module gcs_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // an accepted request keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_result_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result shown while idle");

  // block frees up right after the result
  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("block still busy after result");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("block not idle after reset");

endmodule

bind gradient_color_sampler gcs_checker u_gcs_checker (.*);
